FILE: rtl/core/slt_pkg.sv
`default_nettype none

package slt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;

  // Stream payload widths, whole bytes
  localparam int unsigned S_DATA_W = ((VAL_W + 4 + 7) / 8) * 8;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = ((2 + 4 + 5 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } slt_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/slt_cell.sv
`default_nettype none

module slt_cell (
  input  wire logic                       clk_i,
  input  wire logic [slt_pkg::IDX_W-1:0]  idx_i,
  input  wire slt_pkg::slt_ctrl_t         ctrl_i,
  input  wire logic [slt_pkg::VAL_W-1:0]  prev_entry_i,
  input  wire logic                       prev_gt_i,
  input  wire logic [slt_pkg::VAL_W-1:0]  next_entry_i,
  input  wire logic                       hit_i,
  output logic      [slt_pkg::VAL_W-1:0]  entry_o,
  output logic                            gt_o,
  output logic                            hit_o,
  output logic                            first_o
);

  logic [slt_pkg::VAL_W-1:0] entry_q, entry_d;
  logic [slt_pkg::CNT_W-1:0] idx_ext;
  logic [slt_pkg::CNT_W-1:0] pos_ext;
  logic                      occupied;
  logic                      match;

  assign idx_ext  = slt_pkg::CNT_W'(idx_i);
  assign pos_ext  = slt_pkg::CNT_W'(ctrl_i.position);
  assign occupied = idx_ext < ctrl_i.count;

  // Compare the stored entry against the operand
  assign gt_o  = occupied && ($signed(entry_q) > $signed(ctrl_i.value));
  assign match = occupied && (entry_q == ctrl_i.value);

  // Pass the search hit along the row, mark the first one
  assign first_o = match && !hit_i;
  assign hit_o   = hit_i || match;
  assign entry_o = entry_q;

  // Shift up on insert, shift down on delete, else hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (prev_gt_i) begin
        entry_d = prev_entry_i;
      end else if (gt_o || (idx_ext == ctrl_i.count)) begin
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.del_en && (idx_ext >= pos_ext)) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_list_table.sv
`default_nettype none

// Sorted table of up to 16 signed 32-bit values held in a row of cells, one
// entry per cell. Each transfer carries one operation: insert (after all equal
// entries), delete at a position, or search for the first equal entry. Every
// operation takes effect at the accepting edge: there all cells compare
// against the operand and shift toward or away from their neighbor, and the
// result is registered, showing on the master side in the next cycle. A new item
// is taken in every cycle while the result register is empty or being drained,
// so the block sustains one operation per cycle. The cycle path is the 32-bit
// equality compare in each cell followed by the search-hit ripple across the row.
// Entries past the fill count are never read; reset clears only count and valid.
module sorted_list_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] value, [35:32] position, [39:36] zero
  input  wire logic [slt_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [1:0] mode
  input  wire logic [slt_pkg::S_USER_W-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [1:0] status, [5:2] found_position, [10:6] fill_count, [15:11] zero
  output logic      [slt_pkg::M_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned N = slt_pkg::CAPACITY;

  logic [slt_pkg::CNT_W-1:0] count_q, count_d;
  logic                      out_valid_q;
  logic [slt_pkg::M_DATA_W-1:0] out_data_q, out_data_d;

  logic                      accept;
  slt_pkg::mode_e            mode;
  logic [slt_pkg::VAL_W-1:0] value;
  logic [slt_pkg::IDX_W-1:0] position;
  logic [slt_pkg::CNT_W-1:0] pos_ext;
  logic                      full;
  logic                      pos_ok;
  slt_pkg::slt_ctrl_t        ctrl;
  slt_pkg::status_e          status;
  logic [slt_pkg::IDX_W-1:0] found_pos;

  logic [slt_pkg::VAL_W-1:0] entry_w [N];
  logic [N-1:0]              gt_w;
  logic [N-1:0]              first_w;
  logic [N:0]                hit_w;

  // Unpack the slave transfer
  assign mode     = slt_pkg::mode_e'(s_axis_tuser[1:0]);
  assign value    = s_axis_tdata[slt_pkg::VAL_W-1:0];
  assign position = s_axis_tdata[slt_pkg::VAL_W +: slt_pkg::IDX_W];
  assign pos_ext  = slt_pkg::CNT_W'(position);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full   = count_q >= slt_pkg::CNT_W'(N);
  assign pos_ok = pos_ext < count_q;

  // Broadcast the operation to the row
  always_comb begin
    ctrl          = '0;
    ctrl.value    = value;
    ctrl.position = position;
    ctrl.count    = count_q;
    ctrl.ins_en   = accept && (mode == slt_pkg::MODE_INSERT) && !full;
    ctrl.del_en   = accept && (mode == slt_pkg::MODE_DELETE) && pos_ok;
  end

  // Row of cells
  assign hit_w[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [slt_pkg::VAL_W-1:0] prev_entry;
    logic                      prev_gt;
    logic [slt_pkg::VAL_W-1:0] next_entry;

    if (g == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_entry = entry_w[g-1];
      assign prev_gt    = gt_w[g-1];
    end

    if (g == N - 1) begin : g_last
      assign next_entry = entry_w[g];
    end else begin : g_inner
      assign next_entry = entry_w[g+1];
    end

    slt_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (slt_pkg::IDX_W'(g)),
      .ctrl_i       (ctrl),
      .prev_entry_i (prev_entry),
      .prev_gt_i    (prev_gt),
      .next_entry_i (next_entry),
      .hit_i        (hit_w[g]),
      .entry_o      (entry_w[g]),
      .gt_o         (gt_w[g]),
      .hit_o        (hit_w[g+1]),
      .first_o      (first_w[g])
    );
  end

  // Encode the first matching cell
  always_comb begin
    found_pos = '0;
    for (int i = 0; i < N; i++) begin
      found_pos = found_pos | (first_w[i] ? slt_pkg::IDX_W'(i) : '0);
    end
  end

  // Form the result and the next count
  always_comb begin
    count_d = count_q;
    status  = slt_pkg::ST_OK;
    unique case (mode)
      slt_pkg::MODE_INSERT: begin
        if (full) begin
          status = slt_pkg::ST_FULL;
        end else begin
          count_d = count_q + slt_pkg::CNT_W'(1);
        end
      end
      slt_pkg::MODE_DELETE: begin
        if (!pos_ok) begin
          status = slt_pkg::ST_RANGE;
        end else begin
          count_d = count_q - slt_pkg::CNT_W'(1);
        end
      end
      slt_pkg::MODE_SEARCH: begin
        if (!hit_w[N]) begin
          status = slt_pkg::ST_MISS;
        end
      end
      default: begin
        status = slt_pkg::ST_OK;
      end
    endcase

    out_data_d        = '0;
    out_data_d[1:0]   = status;
    out_data_d[5:2]   = ((mode == slt_pkg::MODE_SEARCH) && hit_w[N]) ? found_pos : '0;
    out_data_d[10:6]  = count_d;
  end

  // Hold the count and the valid flag of the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload on each accepted transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Count never exceeds the row length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slt_pkg::CNT_W'(N))
    else $error("fill count beyond capacity");

  // A pending result reports the count held in the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (m_axis_tdata[10:6] == count_q))
    else $error("reported fill count differs from table count");

  // Only one cell can claim the first search match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_w))
    else $error("more than one first match in the row");

  // Insert into a full table leaves the count unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode == slt_pkg::MODE_INSERT) && full) |=> (count_q == $past(count_q)))
    else $error("count changed on insert into a full table");

endmodule

`default_nettype wire
